@@ rtl/core/color_keyed_sprite_blitter_unit_assert.svh @@
// assertion macros for the color keyed sprite blitter
`ifndef COLOR_KEYED_SPRITE_BLITTER_UNIT_ASSERT_SVH
`define COLOR_KEYED_SPRITE_BLITTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled while rst is high
`define CKB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ckb assertion failed");
// next-cycle implication, disabled while rst is high
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ckb assertion failed");
`else
`define CKB_ASSERT_NOW(label, clk, rst, ante, cons)
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/ckb_pkg.sv @@
// package: types, constants and helpers of the sprite blitter
`default_nettype none
package ckb_pkg;

   localparam int MAX_RECT  = 1024;
   localparam int CNT_W     = 10;
   localparam int SIZE_W    = 11;
   localparam int COORD_W   = 13;
   localparam int ORIGIN_W  = 12;
   localparam int PITCH_W   = 13;
   localparam int COLOR_W   = 32;
   localparam int ADDR_W    = 22;
   localparam int POS_W     = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // playfield window, inclusive (lies strictly inside the screen)
   localparam logic signed [COORD_W-1:0] PF_LEFT   = 13'sd280;
   localparam logic signed [COORD_W-1:0] PF_RIGHT  = 13'sd919;
   localparam logic signed [COORD_W-1:0] PF_TOP    = 13'sd141;
   localparam logic signed [COORD_W-1:0] PF_BOTTOM = 13'sd626;

   // reset values of the control registers
   localparam logic [SIZE_W-1:0]  RESET_SIZE  = 11'd1;
   localparam logic [PITCH_W-1:0] RESET_PITCH = 13'd1200;
   localparam logic [COLOR_W-1:0] RESET_KEY   = 32'hFF64_6464;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_RECT_WIDTH  = 3'd2,
      CSR_RECT_HEIGHT = 3'd3,
      CSR_MIRROR      = 3'd4,
      CSR_ROW_PITCH   = 3'd5,
      CSR_KEY_COLOR   = 3'd6
   } ckb_csr_type;

   typedef struct packed {
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
      logic [SIZE_W-1:0]          rect_width;
      logic [SIZE_W-1:0]          rect_height;
      logic                       mirror;
      logic [PITCH_W-1:0]         row_pitch;
      logic [COLOR_W-1:0]         key_color;
   } ckb_cfg_type;

   // one pixel between the cursor stage and the address stage
   typedef struct packed {
      logic               write_enable;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [COLOR_W-1:0] color;
      logic               rect_done;
   } ckb_pix_type;

   // zero counts as one, anything above the maximum as the maximum
   function automatic logic [SIZE_W-1:0] ckb_clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_RECT)) begin
         r = SIZE_W'(MAX_RECT);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/ckb_chan_if.sv @@
// valid/ready channel interfaces for pixel requests and write responses
`default_nettype none
interface ckb_req_if import ckb_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_color;

   modport source (output valid, output pixel_color, input ready);
   modport sink   (input valid, input pixel_color, output ready);
endinterface

interface ckb_rsp_if import ckb_pkg::*;;
   logic               valid;
   logic               ready;
   logic               write_enable;
   logic [ADDR_W-1:0]  dest_address;
   logic [COLOR_W-1:0] out_color;
   logic               rect_done;

   modport source (output valid, output write_enable, output dest_address,
                   output out_color, output rect_done, input ready);
   modport sink   (input valid, input write_enable, input dest_address,
                   input out_color, input rect_done, output ready);
endinterface
`default_nettype wire

@@ rtl/core/color_keyed_sprite_blitter_unit.sv @@
// Path: a pixel is registered in the cursor stage, then in the result register, from which it transfers out.
// Throughput: one pixel per cycle unless the result side stalls; both register stages (cursor stage, then the
// pitch multiply and add into the result register) reload while they drain.
// Reset: synchronous, active high; clears both counters, empties both
// stages and loads the register defaults (pitch 1200, key 0xFF646464).
`default_nettype none
`include "color_keyed_sprite_blitter_unit_assert.svh"
module color_keyed_sprite_blitter_unit import ckb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   ckb_req_if.sink                    req_chan,
   ckb_rsp_if.source                  rsp_chan
);

   ckb_cfg_type cfg_ff, cfg_in;
   logic        stage_valid;
   logic        stage_take;
   ckb_pix_type stage_pix;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (ckb_csr_type'(csr_index))
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_write_data[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_write_data[ORIGIN_W-1:0];
            CSR_RECT_WIDTH:  cfg_in.rect_width  = csr_write_data[SIZE_W-1:0];
            CSR_RECT_HEIGHT: cfg_in.rect_height = csr_write_data[SIZE_W-1:0];
            CSR_MIRROR:      cfg_in.mirror      = csr_write_data[0];
            CSR_ROW_PITCH:   cfg_in.row_pitch   = csr_write_data[PITCH_W-1:0];
            CSR_KEY_COLOR:   cfg_in.key_color   = csr_write_data[COLOR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.rect_width  <= RESET_SIZE;
         cfg_ff.rect_height <= RESET_SIZE;
         cfg_ff.mirror      <= 1'b0;
         cfg_ff.row_pitch   <= RESET_PITCH;
         cfg_ff.key_color   <= RESET_KEY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // counters, position and clip
   ckb_cursor u_cursor (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_chan    (req_chan),
      .stage_take  (stage_take),
      .stage_valid (stage_valid),
      .stage_pix   (stage_pix)
   );

   // address and result register
   ckb_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .row_pitch   (cfg_ff.row_pitch),
      .stage_valid (stage_valid),
      .stage_pix   (stage_pix),
      .stage_take  (stage_take),
      .rsp_chan    (rsp_chan)
   );

   // dropped pixels carry a zero address
   `CKB_ASSERT_NOW(a_drop_addr_zero, clock, reset, rsp_chan.valid && !rsp_chan.write_enable, rsp_chan.dest_address == '0)
   // input stalls only under result backpressure
   `CKB_ASSERT_NOW(a_stall_cause, clock, reset, !req_chan.ready, rsp_chan.valid && !rsp_chan.ready)
   // nothing comes out right after reset
   `CKB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_chan.valid)
   // a drained, empty pipe is ready for input
   `CKB_ASSERT_NEXT(a_empty_ready, clock, reset, !req_chan.valid && !rsp_chan.valid && !stage_valid, req_chan.ready)

endmodule
`default_nettype wire

@@ rtl/core/ckb_cursor.sv @@
// cursor stage: column/row counters, destination position, key and clip test
`default_nettype none
module ckb_cursor import ckb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ckb_cfg_type cfg,
   ckb_req_if.sink          req_chan,
   input  wire logic        stage_take,
   output logic             stage_valid,
   output ckb_pix_type      stage_pix
);

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             valid_ff, valid_in;
   ckb_pix_type      pix_ff, pix_in;

   logic [SIZE_W-1:0]         w_size, h_size;
   logic [CNT_W-1:0]          w_last, h_last;
   logic [CNT_W-1:0]          col_c, row_c;
   logic                      col_last, row_last;
   logic signed [COORD_W-1:0] x_pos, y_pos;
   logic signed [COORD_W-1:0] ox_ext, oy_ext;
   logic                      in_window;
   logic                      transfer;

   // stage can take a new pixel when empty or being drained
   assign req_chan.ready = !valid_ff || stage_take;
   assign transfer       = req_chan.valid && req_chan.ready;

   // effective rectangle size and last indexes
   always_comb begin
      w_size = ckb_clamp_size(cfg.rect_width);
      h_size = ckb_clamp_size(cfg.rect_height);
      w_last = CNT_W'(w_size - SIZE_W'(1));
      h_last = CNT_W'(h_size - SIZE_W'(1));
   end

   // counters beyond a shrunken size sit at the last index
   always_comb begin
      col_c    = (col_ff > w_last) ? w_last : col_ff;
      row_c    = (row_ff > h_last) ? h_last : row_ff;
      col_last = (col_c == w_last);
      row_last = (row_c == h_last);
   end

   // destination position, mirrored or straight
   always_comb begin
      ox_ext = COORD_W'(cfg.origin_x);
      oy_ext = COORD_W'(cfg.origin_y);
      if (cfg.mirror) begin
         x_pos = $signed({2'b00, w_size}) - $signed({3'b000, col_c}) + ox_ext;
      end else begin
         x_pos = $signed({3'b000, col_c}) + ox_ext;
      end
      y_pos = $signed({3'b000, row_c}) + oy_ext;
      in_window = (x_pos >= PF_LEFT) && (x_pos <= PF_RIGHT)
               && (y_pos >= PF_TOP) && (y_pos <= PF_BOTTOM);
   end

   // next counter values and stage contents
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      valid_in = valid_ff;
      pix_in   = pix_ff;
      if (stage_take) begin
         valid_in = 1'b0;
      end
      if (transfer) begin
         valid_in            = 1'b1;
         pix_in.write_enable = in_window && (req_chan.pixel_color != cfg.key_color);
         pix_in.pos_x        = x_pos[POS_W-1:0];
         pix_in.pos_y        = y_pos[POS_W-1:0];
         pix_in.color        = req_chan.pixel_color;
         pix_in.rect_done    = col_last && row_last;
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_c + CNT_W'(1);
         end else begin
            col_in = col_c + CNT_W'(1);
            row_in = row_c;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign stage_valid = valid_ff;
   assign stage_pix   = pix_ff;

endmodule
`default_nettype wire

@@ rtl/core/ckb_addr.sv @@
// address stage: frame buffer index x + pitch * y into the result register
`default_nettype none
module ckb_addr import ckb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [PITCH_W-1:0] row_pitch,
   input  wire logic               stage_valid,
   input  wire ckb_pix_type        stage_pix,
   output logic                    stage_take,
   ckb_rsp_if.source               rsp_chan
);

   logic               valid_ff, valid_in;
   logic               we_ff;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COLOR_W-1:0] color_ff;
   logic               done_ff;

   logic [PITCH_W+POS_W-1:0] product;
   logic [PITCH_W+POS_W-1:0] sum;

   // result register loads when empty or being drained
   assign stage_take = stage_valid && (!valid_ff || rsp_chan.ready);

   // address, zero for a dropped pixel
   always_comb begin
      product = (PITCH_W+POS_W)'(row_pitch) * (PITCH_W+POS_W)'(stage_pix.pos_y);
      sum     = product + (PITCH_W+POS_W)'(stage_pix.pos_x);
      addr_in = stage_pix.write_enable ? sum[ADDR_W-1:0] : '0;
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (stage_take) begin
         valid_in = 1'b1;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (stage_take) begin
         we_ff    <= stage_pix.write_enable;
         addr_ff  <= addr_in;
         color_ff <= stage_pix.color;
         done_ff  <= stage_pix.rect_done;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.write_enable = we_ff;
   assign rsp_chan.dest_address = addr_ff;
   assign rsp_chan.out_color    = color_ff;
   assign rsp_chan.rect_done    = done_ff;

endmodule
`default_nettype wire

@@ tb/color_keyed_sprite_blitter_unit_tb.sv @@
// testbench for the color keyed sprite blitter: directed table, random sprites, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module color_keyed_sprite_blitter_unit_tb;
   import ckb_pkg::*;

   localparam int SCREEN_W     = 1200;
   localparam int SCREEN_H     = 675;
   localparam int RANDOM_ITEMS = 1850;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 4;
   // index that maps to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic               write_enable;
      logic [ADDR_W-1:0]  dest_address;
      logic [COLOR_W-1:0] out_color;
      logic               rect_done;
   } blit_write_type;

   typedef enum logic {ROW_CFG, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           value;
      logic                  known;
      logic                  write_enable;
      logic [ADDR_W-1:0]     dest_address;
      logic                  rect_done;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   ckb_req_if req_if ();
   ckb_rsp_if rsp_if ();

   color_keyed_sprite_blitter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   // blitter shadow state
   ckb_cfg_type cfg_shadow;
   int unsigned col_pos;
   int unsigned row_pos;

   blit_write_type pending_writes[$];
   stim_row_type   stim_rows[$];

   int  errors;
   int  results_seen;
   int  drawn_pixels;
   int  rects_done;
   int  pixels_sent;
   int  quiet_cycles;
   int  stall_left;
   bit  steady;
   bit  csr_armed;

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // next destination write for one source pixel, advancing the cursor
   function automatic blit_write_type blit_pixel(input logic [COLOR_W-1:0] color);
      blit_write_type r;
      int w, h, col, row, x, y;
      logic draw;
      w = int'(cfg_shadow.rect_width);
      h = int'(cfg_shadow.rect_height);
      if (w == 0) w = 1;
      else if (w > MAX_RECT) w = MAX_RECT;
      if (h == 0) h = 1;
      else if (h > MAX_RECT) h = MAX_RECT;
      col = (col_pos > w - 1) ? w - 1 : col_pos;
      row = (row_pos > h - 1) ? h - 1 : row_pos;
      if (cfg_shadow.mirror) x = w - col + int'(cfg_shadow.origin_x);
      else x = col + int'(cfg_shadow.origin_x);
      y = row + int'(cfg_shadow.origin_y);
      draw = (color != cfg_shadow.key_color) && x > 0 && x < SCREEN_W && y > 0 && y < SCREEN_H
         && x >= PF_LEFT && x <= PF_RIGHT && y >= PF_TOP && y <= PF_BOTTOM;
      r.write_enable = draw;
      r.dest_address = draw ? ADDR_W'(x + int'(cfg_shadow.row_pitch) * y) : '0;
      r.out_color    = color;
      r.rect_done    = (col == w - 1) && (row == h - 1);
      // cursor moves along the row, wraps to the next row, then to the top
      if (col == w - 1) begin
         col_pos = 0;
         row_pos = (row == h - 1) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
      return r;
   endfunction

   // keep the low bits of a register value, fill the rest with noise
   function automatic logic [31:0] keep_low(input logic [31:0] v, input int bits);
      logic [31:0] m;
      m = (32'h1 << bits) - 32'h1;
      return (v & m) | ($urandom & ~m);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll < 4) return cfg_shadow.key_color;
      if (roll == 4) return cfg_shadow.key_color ^ (32'h1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [31:0] v);
      stim_row_type s;
      s = '{ROW_CFG, idx, v, 1'b0, 1'b0, '0, 1'b0};
      return s;
   endfunction

   function automatic stim_row_type pix_row(input logic [COLOR_W-1:0] c);
      stim_row_type s;
      s = '{ROW_PIX, CSR_SPARE, c, 1'b0, 1'b0, '0, 1'b0};
      return s;
   endfunction

   function automatic stim_row_type pix_known(input logic [COLOR_W-1:0] c, input logic we,
                                              input logic [ADDR_W-1:0] addr, input logic done);
      stim_row_type s;
      s = '{ROW_PIX, CSR_SPARE, c, 1'b1, we, addr, done};
      return s;
   endfunction

   // register write, mirrored into the shadow copy
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_ORIGIN_X:    cfg_shadow.origin_x    = data[ORIGIN_W-1:0];
         CSR_ORIGIN_Y:    cfg_shadow.origin_y    = data[ORIGIN_W-1:0];
         CSR_RECT_WIDTH:  cfg_shadow.rect_width  = data[SIZE_W-1:0];
         CSR_RECT_HEIGHT: cfg_shadow.rect_height = data[SIZE_W-1:0];
         CSR_MIRROR:      cfg_shadow.mirror      = data[0];
         CSR_ROW_PITCH:   cfg_shadow.row_pitch   = data[PITCH_W-1:0];
         CSR_KEY_COLOR:   cfg_shadow.key_color   = data;
         default: ;
      endcase
      @(posedge clock);
      csr_armed = 1'b1;
   endtask

   // one pixel transfer; the expected write is queued once it is accepted
   task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic known,
                             input blit_write_type known_write, output logic done);
      int gap;
      blit_write_type predicted;
      gap = pick_gap();
      if (csr_armed) begin
         csr_write_enable <= 1'b0;
         csr_armed = 1'b0;
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.pixel_color <= color;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = blit_pixel(color);
      pending_writes.push_back(known ? known_write : predicted);
      pixels_sent++;
      done = predicted.rect_done;
   endtask

   // stop sending and wait for every outstanding write
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   // result side: scoreboard, ready pattern and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_writes.size() == 0) begin
               $error("write transfer with no pixel outstanding");
               errors++;
            end else begin
               blit_write_type exp_w;
               exp_w = pending_writes.pop_front();
               results_seen++;
               if (rsp_if.write_enable) drawn_pixels++;
               if (rsp_if.rect_done) rects_done++;
               if (rsp_if.write_enable !== exp_w.write_enable) begin
                  $error("write_enable: expected %0d, got %0d",
                         exp_w.write_enable, rsp_if.write_enable);
                  errors++;
               end
               if (rsp_if.dest_address !== exp_w.dest_address) begin
                  $error("dest_address: expected %0d, got %0d",
                         exp_w.dest_address, rsp_if.dest_address);
                  errors++;
               end
               if (rsp_if.out_color !== exp_w.out_color) begin
                  $error("out_color: expected %h, got %h", exp_w.out_color, rsp_if.out_color);
                  errors++;
               end
               if (rsp_if.rect_done !== exp_w.rect_done) begin
                  $error("rect_done: expected %0d, got %0d", exp_w.rect_done, rsp_if.rect_done);
                  errors++;
               end
            end
         end
         // watchdog on cycles with no transfer at all
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
               $display("Some tests failed");
               $finish;
            end
         end
         // receiver stalls
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      stim_row_type   s;
      blit_write_type known_write;
      logic           done;
      int             ox, oy, n, lim;
      logic [31:0]    data;

      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_index          <= CSR_ORIGIN_X;
      csr_write_data     <= '0;
      req_if.valid       <= 1'b0;
      req_if.pixel_color <= '0;
      errors       = 0;
      results_seen = 0;
      drawn_pixels = 0;
      rects_done   = 0;
      pixels_sent  = 0;
      steady       = 1'b0;
      csr_armed    = 1'b0;
      col_pos      = 0;
      row_pos      = 0;
      cfg_shadow   = '{origin_x: '0, origin_y: '0, rect_width: RESET_SIZE,
                       rect_height: RESET_SIZE, mirror: 1'b0, row_pitch: RESET_PITCH,
                       key_color: RESET_KEY};

      // directed rows: defaults, playfield corners, clipping, pitch and size corners
      stim_rows.push_back(pix_known(32'h1234_5678, 1'b0, '0, 1'b1));
      stim_rows.push_back(pix_known(RESET_KEY, 1'b0, '0, 1'b1));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'd280));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_Y, 32'd141));
      stim_rows.push_back(pix_known(32'hFFFF_FFFF, 1'b1, 22'(280 + 1200 * 141), 1'b1));
      stim_rows.push_back(pix_known(32'h0000_0000, 1'b1, 22'(280 + 1200 * 141), 1'b1));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'd919));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_Y, 32'd626));
      stim_rows.push_back(pix_known(32'hAAAA_AAAA, 1'b1, 22'(919 + 1200 * 626), 1'b1));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'd920));
      stim_rows.push_back(pix_known(32'h5555_5555, 1'b0, '0, 1'b1));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'd279));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_Y, 32'd140));
      stim_rows.push_back(pix_known(32'h0000_0001, 1'b0, '0, 1'b1));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'hFFFF_F800));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_Y, 32'h0000_07FF));
      stim_rows.push_back(pix_known(32'h8000_0000, 1'b0, '0, 1'b1));
      // widest pitch wraps the address
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'd500));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_Y, 32'd600));
      stim_rows.push_back(cfg_row(CSR_ROW_PITCH, 32'hFFFF_FFFF));
      stim_rows.push_back(pix_row(32'h0F0F_0F0F));
      stim_rows.push_back(cfg_row(CSR_ROW_PITCH, 32'd0));
      stim_rows.push_back(pix_known(32'hF0F0_F0F0, 1'b1, 22'd500, 1'b1));
      // zero sizes act as one
      stim_rows.push_back(cfg_row(CSR_ROW_PITCH, 32'd1200));
      stim_rows.push_back(cfg_row(CSR_RECT_WIDTH, 32'd0));
      stim_rows.push_back(cfg_row(CSR_RECT_HEIGHT, 32'd0));
      stim_rows.push_back(pix_known(32'h1111_1111, 1'b1, 22'(500 + 1200 * 600), 1'b1));
      // small mirrored sprite with one keyed pixel
      stim_rows.push_back(cfg_row(CSR_RECT_WIDTH, 32'd3));
      stim_rows.push_back(cfg_row(CSR_RECT_HEIGHT, 32'd2));
      stim_rows.push_back(cfg_row(CSR_MIRROR, 32'd1));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_X, 32'd400));
      stim_rows.push_back(cfg_row(CSR_ORIGIN_Y, 32'd200));
      stim_rows.push_back(pix_row(32'h0102_0304));
      stim_rows.push_back(pix_row(32'h0506_0708));
      stim_rows.push_back(pix_row(RESET_KEY));
      stim_rows.push_back(pix_row(32'h090A_0B0C));
      stim_rows.push_back(pix_row(32'h0D0E_0F10));
      stim_rows.push_back(pix_row(32'h1112_1314));
      // size shrunk under a running cursor
      stim_rows.push_back(cfg_row(CSR_RECT_WIDTH, 32'd4));
      stim_rows.push_back(cfg_row(CSR_MIRROR, 32'hFFFF_FFFE));
      stim_rows.push_back(pix_row(32'h2222_2222));
      stim_rows.push_back(pix_row(32'h3333_3333));
      stim_rows.push_back(cfg_row(CSR_RECT_WIDTH, 32'd1));
      stim_rows.push_back(pix_row(32'h4444_4444));
      stim_rows.push_back(cfg_row(CSR_RECT_HEIGHT, 32'd1));
      stim_rows.push_back(pix_row(32'h6666_6666));
      // oversize width clamps to the maximum
      stim_rows.push_back(cfg_row(CSR_RECT_WIDTH, 32'd2047));
      stim_rows.push_back(pix_row(32'h7777_7777));
      stim_rows.push_back(cfg_row(CSR_RECT_WIDTH, 32'd1));
      stim_rows.push_back(pix_row(32'h8888_8888));
      stim_rows.push_back(cfg_row(CSR_SPARE, 32'hFFFF_FFFF));
      stim_rows.push_back(pix_row(32'h9999_9999));
      // key color extremes
      stim_rows.push_back(cfg_row(CSR_KEY_COLOR, 32'h0000_0000));
      stim_rows.push_back(pix_known(32'h0000_0000, 1'b0, '0, 1'b1));
      stim_rows.push_back(cfg_row(CSR_KEY_COLOR, 32'hFFFF_FFFF));
      stim_rows.push_back(pix_known(32'hFFFF_FFFF, 1'b0, '0, 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (stim_rows[i]) begin
         s = stim_rows[i];
         if (s.kind == ROW_CFG) begin
            drain();
            csr_write(s.index, s.value);
         end else begin
            known_write = '{s.write_enable, s.dest_address, s.value, s.rect_done};
            send_pixel(s.value, s.known, known_write, done);
         end
      end

      // random sprites, with the odd burst of noise writes and broken rectangles
      known_write = '{1'b0, '0, '0, 1'b0};
      pixels_sent = 0;
      while (pixels_sent < RANDOM_ITEMS) begin
         drain();
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            ox = $urandom_range(230, 960);
            oy = $urandom_range(100, 660);
            csr_write(CSR_ORIGIN_X, keep_low(32'(ox), ORIGIN_W));
            csr_write(CSR_ORIGIN_Y, keep_low(32'(oy), ORIGIN_W));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            csr_write(CSR_RECT_WIDTH, keep_low(32'(n), SIZE_W));
            csr_write(CSR_RECT_HEIGHT, keep_low(32'($urandom_range(1, 8)), SIZE_W));
            csr_write(CSR_MIRROR, $urandom);
            if ($urandom_range(0, 4) == 0) csr_write(CSR_ROW_PITCH, $urandom);
            else csr_write(CSR_ROW_PITCH, keep_low(32'd1200, PITCH_W));
            if ($urandom_range(0, 3) == 0) csr_write(CSR_KEY_COLOR, $urandom);
            // stream until the cursor closes the rectangle
            lim = 0;
            do begin
               send_pixel(pick_color(), 1'b0, known_write, done);
               lim++;
            end while (!done && lim < 4 * MAX_RECT);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 4))
                  0: data = 32'h0000_0000;
                  1: data = 32'hFFFF_FFFF;
                  2: data = 32'h0000_0800;
                  3: data = 32'h0000_07FF;
                  default: data = $urandom;
               endcase
               csr_write(CSR_IDX_W'($urandom_range(0, 7)), data);
            end
            repeat ($urandom_range(1, 40)) send_pixel(pick_color(), 1'b0, known_write, done);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d pixel writes: %0d drawn, %0d rectangles closed",
               results_seen, drawn_pixels, rects_done);
      $display("covered playfield edges, mirroring, keying, size clamps and pitch wrap");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ color_keyed_sprite_blitter_unit.f @@
+incdir+rtl/core
rtl/core/ckb_pkg.sv
rtl/core/ckb_chan_if.sv
rtl/core/ckb_cursor.sv
rtl/core/ckb_addr.sv
rtl/core/color_keyed_sprite_blitter_unit.sv
tb/color_keyed_sprite_blitter_unit_tb.sv
